// ----- design/ssp_pkg.sv -----
// Shared constants for the snapshot stream parser: event codes, opcodes,
// length-prefix forms and the file magic. No dependencies.
package ssp_pkg;

  localparam int unsigned EventW = 4;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned ExpW   = 64;

  localparam logic [EventW-1:0] EV_NONE      = 4'd0;
  localparam logic [EventW-1:0] EV_KEY_BYTE  = 4'd1;
  localparam logic [EventW-1:0] EV_VAL_BYTE  = 4'd2;
  localparam logic [EventW-1:0] EV_REC_DONE  = 4'd3;
  localparam logic [EventW-1:0] EV_LOADED_OK = 4'd4;
  localparam logic [EventW-1:0] EV_BAD_MAGIC = 4'd5;
  localparam logic [EventW-1:0] EV_BAD_OP    = 4'd6;
  localparam logic [EventW-1:0] EV_ENC_STR   = 4'd7;
  localparam logic [EventW-1:0] EV_TRUNC     = 4'd8;

  localparam logic [ByteW-1:0] OP_SELECT_DB = 8'hFE;
  localparam logic [ByteW-1:0] OP_RESIZE_DB = 8'hFB;
  localparam logic [ByteW-1:0] OP_AUX       = 8'hFA;
  localparam logic [ByteW-1:0] OP_EXPIRE_S  = 8'hFD;
  localparam logic [ByteW-1:0] OP_EXPIRE_MS = 8'hFC;
  localparam logic [ByteW-1:0] OP_EOF       = 8'hFF;
  localparam logic [ByteW-1:0] OP_KV_STRING = 8'h00;

  localparam logic [1:0] LEN_6BIT    = 2'd0;
  localparam logic [1:0] LEN_14BIT   = 2'd1;
  localparam logic [1:0] LEN_32BIT   = 2'd2;
  localparam logic [5:0] LEN_LOW_MSK = 6'h3F;

  localparam logic [9:0] MS_PER_S = 10'd1000;

  localparam logic [3:0] MAGIC_LEN   = 4'd5;
  localparam logic [3:0] VERSION_LEN = 4'd4;

  function automatic logic [ByteW-1:0] magic_byte(input logic [2:0] idx);
    logic [ByteW-1:0] r;
    case (idx)
      3'd0:    r = 8'h52;
      3'd1:    r = 8'h45;
      3'd2:    r = 8'h44;
      3'd3:    r = 8'h49;
      3'd4:    r = 8'h53;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ----- design/snapshot_stream_parser.sv -----
// Snapshot stream parser: one file byte or end-of-file marker per input
// transfer, one event per output transfer. Depends on ssp_pkg.
//
// Usage:
//   Input channel  (in_valid_i / in_ready_o): func_i = 1 marks end of file,
//     else data_byte_i carries the next file byte.
//   Output channel (out_valid_o / out_ready_i): every input transfer yields
//     exactly one output transfer carrying event_res_o, out_byte_o and
//     expire_ms_o (the held expiry on a record-done event).
//   Registered output: the event appears in the cycle after its input transfer.
//   Throughput: one byte per cycle unless the output stalls; the parse state
//     and the one-deep result register both update in the cycle of the transfer.
//   Stall: while a result waits and out_ready_i is low, in_ready_o is low;
//     with out_ready_i high a new byte is taken in the same cycle the
//     waiting result leaves.
//   Reset: rst_ni clears the parser to the magic check and drops any
//     pending result. After end of data, bad magic, a bad opcode, an encoded
//     string or truncation the parser halts and reports event 0 for every
//     further byte until reset.
module snapshot_stream_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         func_i,
  input  logic [ssp_pkg::ByteW-1:0]    data_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ssp_pkg::EventW-1:0]   event_res_o,
  output logic [ssp_pkg::ByteW-1:0]    out_byte_o,
  output logic [ssp_pkg::ExpW-1:0]     expire_ms_o
);
  import ssp_pkg::*;

  localparam logic [2:0] PH_MAGIC    = 3'd0;
  localparam logic [2:0] PH_VERSION  = 3'd1;
  localparam logic [2:0] PH_OPCODE   = 3'd2;
  localparam logic [2:0] PH_LENFIRST = 3'd3;
  localparam logic [2:0] PH_LENMORE  = 3'd4;
  localparam logic [2:0] PH_STRING   = 3'd5;
  localparam logic [2:0] PH_EXPIRY   = 3'd6;
  localparam logic [2:0] PH_HALT     = 3'd7;

  localparam logic [2:0] ROLE_DBNUM  = 3'd0;
  localparam logic [2:0] ROLE_HSIZE  = 3'd1;
  localparam logic [2:0] ROLE_ESIZE  = 3'd2;
  localparam logic [2:0] ROLE_AUXKEY = 3'd3;
  localparam logic [2:0] ROLE_AUXVAL = 3'd4;
  localparam logic [2:0] ROLE_KEY    = 3'd5;
  localparam logic [2:0] ROLE_VALUE  = 3'd6;

  logic [2:0]       phase_q, phase_d;
  logic [3:0]       cnt_q, cnt_d;
  logic [63:0]      acc_q, acc_d;
  logic [31:0]      left_q, left_d;
  logic [2:0]       role_q, role_d;
  logic [63:0]      pend_q, pend_d;
  logic             secs_q, secs_d;

  logic             out_valid_q;
  logic [EventW-1:0] ev_q;
  logic [ByteW-1:0] ob_q;
  logic [ExpW-1:0]  oe_q;

  logic [EventW-1:0] ev_d;
  logic [ByteW-1:0] ob_d;
  logic [ExpW-1:0]  oe_d;

  logic             accept;
  logic             len_fire, len_special, str_over, rec_done;
  logic [31:0]      len_val, left_dec, skip_n;
  logic [ByteW-1:0] rec_byte;
  logic [63:0]      acc_or, byte_sh;
  logic [41:0]      sec_ms;
  logic [3:0]       cnt_inc;
  logic [3:0]       exp_need;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign byte_sh  = {56'd0, data_byte_i} << {cnt_q[2:0], 3'b000};
  assign acc_or   = acc_q | byte_sh;
  assign sec_ms   = {10'd0, acc_or[31:0]} * {32'd0, MS_PER_S};
  assign cnt_inc  = cnt_q + 4'd1;
  assign left_dec = (left_q != 32'd0) ? left_q - 32'd1 : left_q;
  assign exp_need = secs_q ? 4'd4 : 4'd8;

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    left_d      = left_q;
    role_d      = role_q;
    pend_d      = pend_q;
    secs_d      = secs_q;
    ev_d        = EV_NONE;
    ob_d        = '0;
    oe_d        = '0;
    len_fire    = 1'b0;
    len_special = 1'b0;
    len_val     = '0;
    str_over    = 1'b0;
    rec_done    = 1'b0;
    rec_byte    = '0;
    skip_n      = '0;

    if (phase_q == PH_HALT) begin
      phase_d = PH_HALT;
    end else if (func_i) begin
      ev_d    = (phase_q == PH_OPCODE) ? EV_LOADED_OK : EV_TRUNC;
      phase_d = PH_HALT;
    end else begin
      case (phase_q)
        PH_MAGIC: begin
          acc_d = acc_q | {63'd0, data_byte_i != magic_byte(cnt_q[2:0])};
          cnt_d = cnt_inc;
          if (cnt_inc >= MAGIC_LEN) begin
            if (acc_d[0]) begin
              ev_d    = EV_BAD_MAGIC;
              phase_d = PH_HALT;
            end else begin
              phase_d = PH_VERSION;
            end
            cnt_d = '0;
            acc_d = '0;
          end
        end
        PH_VERSION: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= VERSION_LEN) begin
            cnt_d   = '0;
            phase_d = PH_OPCODE;
          end
        end
        PH_OPCODE: begin
          case (data_byte_i)
            OP_SELECT_DB: begin
              role_d  = ROLE_DBNUM;
              phase_d = PH_LENFIRST;
            end
            OP_RESIZE_DB: begin
              role_d  = ROLE_HSIZE;
              phase_d = PH_LENFIRST;
            end
            OP_AUX: begin
              role_d  = ROLE_AUXKEY;
              phase_d = PH_LENFIRST;
            end
            OP_KV_STRING: begin
              role_d  = ROLE_KEY;
              phase_d = PH_LENFIRST;
            end
            OP_EXPIRE_S, OP_EXPIRE_MS: begin
              secs_d  = (data_byte_i == OP_EXPIRE_S);
              acc_d   = '0;
              cnt_d   = '0;
              phase_d = PH_EXPIRY;
            end
            OP_EOF: begin
              ev_d    = EV_LOADED_OK;
              phase_d = PH_HALT;
            end
            default: begin
              ev_d    = EV_BAD_OP;
              phase_d = PH_HALT;
            end
          endcase
        end
        PH_LENFIRST: begin
          case (data_byte_i[7:6])
            LEN_6BIT: begin
              len_fire = 1'b1;
              len_val  = {26'd0, data_byte_i[5:0] & LEN_LOW_MSK};
            end
            LEN_14BIT: begin
              acc_d   = {58'd0, data_byte_i[5:0] & LEN_LOW_MSK};
              cnt_d   = 4'd1;
              phase_d = PH_LENMORE;
            end
            LEN_32BIT: begin
              acc_d   = '0;
              cnt_d   = 4'd4;
              phase_d = PH_LENMORE;
            end
            default: begin
              len_fire    = 1'b1;
              len_special = 1'b1;
              len_val     = {26'd0, data_byte_i[5:0] & LEN_LOW_MSK};
            end
          endcase
        end
        PH_LENMORE: begin
          acc_d = {32'd0, acc_q[23:0], data_byte_i};
          cnt_d = (cnt_q != 4'd0) ? cnt_q - 4'd1 : cnt_q;
          if (cnt_d == 4'd0) begin
            len_fire = 1'b1;
            len_val  = acc_d[31:0];
          end
        end
        PH_STRING: begin
          left_d = left_dec;
          if (role_q == ROLE_KEY) begin
            ev_d = EV_KEY_BYTE;
            ob_d = data_byte_i;
            if (left_dec == 32'd0) str_over = 1'b1;
          end else if (role_q == ROLE_VALUE) begin
            if (left_dec == 32'd0) begin
              rec_done = 1'b1;
              rec_byte = data_byte_i;
            end else begin
              ev_d = EV_VAL_BYTE;
              ob_d = data_byte_i;
            end
          end else if (left_dec == 32'd0) begin
            str_over = 1'b1;
          end
        end
        PH_EXPIRY: begin
          acc_d = acc_or;
          cnt_d = cnt_inc;
          if (cnt_inc >= exp_need) begin
            pend_d  = secs_q ? {22'd0, sec_ms} : acc_or;
            acc_d   = '0;
            cnt_d   = '0;
            phase_d = PH_OPCODE;
          end
        end
        default: begin
          phase_d = PH_HALT;
        end
      endcase

      if (len_fire) begin
        case (role_q)
          ROLE_HSIZE: begin
            role_d  = ROLE_ESIZE;
            phase_d = PH_LENFIRST;
          end
          ROLE_AUXKEY, ROLE_AUXVAL: begin
            if (len_special && len_val > 32'd2) begin
              ev_d    = EV_ENC_STR;
              phase_d = PH_HALT;
            end else begin
              if (len_special) begin
                skip_n = 32'd1 << len_val[1:0];
              end else begin
                skip_n = len_val;
              end
              if (skip_n == 32'd0) begin
                str_over = 1'b1;
              end else begin
                left_d  = skip_n;
                phase_d = PH_STRING;
              end
            end
          end
          ROLE_KEY, ROLE_VALUE: begin
            if (len_special) begin
              ev_d    = EV_ENC_STR;
              phase_d = PH_HALT;
            end else if (len_val == 32'd0) begin
              if (role_q == ROLE_VALUE) rec_done = 1'b1;
              else str_over = 1'b1;
            end else begin
              left_d  = len_val;
              phase_d = PH_STRING;
            end
          end
          default: begin
            phase_d = PH_OPCODE;
          end
        endcase
      end

      if (str_over) begin
        if (role_q == ROLE_AUXKEY) begin
          role_d  = ROLE_AUXVAL;
          phase_d = PH_LENFIRST;
        end else if (role_q == ROLE_KEY) begin
          role_d  = ROLE_VALUE;
          phase_d = PH_LENFIRST;
        end else begin
          phase_d = PH_OPCODE;
        end
      end

      if (rec_done) begin
        ev_d    = EV_REC_DONE;
        ob_d    = rec_byte;
        oe_d    = pend_q;
        pend_d  = '0;
        phase_d = PH_OPCODE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MAGIC;
      cnt_q   <= '0;
      acc_q   <= '0;
      left_q  <= '0;
      role_q  <= ROLE_DBNUM;
      pend_q  <= '0;
      secs_q  <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      left_q  <= left_d;
      role_q  <= role_d;
      pend_q  <= pend_d;
      secs_q  <= secs_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ev_q <= ev_d;
      ob_q <= ob_d;
      oe_q <= oe_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign event_res_o = ev_q;
  assign out_byte_o  = ob_q;
  assign expire_ms_o = oe_q;

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while result stalled");

  a_halt_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HALT |=> phase_q == PH_HALT)
    else $error("parser left halt without reset");

  a_expiry_only_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o != EV_REC_DONE |-> expire_ms_o == '0)
    else $error("expiry on an event other than record done");

  a_byte_only_on_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o != EV_KEY_BYTE && event_res_o != EV_VAL_BYTE
      && event_res_o != EV_REC_DONE |-> out_byte_o == '0)
    else $error("data byte on a status event");

endmodule

// ----- tb/snapshot_stream_parser_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for snapshot_stream_parser: feeds one generated snapshot file
// through the input channel and compares each output transfer with a cycle-free
// predictor of the parser. Depends on ssp_pkg and the parser RTL only.
module snapshot_stream_parser_test;
  import ssp_pkg::*;

  localparam int unsigned ITEM_TARGET  = 540;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned TAIL_CYCLES  = 4;

  localparam logic [1:0] LEN_SPECIAL = 2'd3;
  localparam logic [5:0] ENC_INT8    = 6'd0;
  localparam logic [5:0] ENC_INT16   = 6'd1;
  localparam logic [5:0] ENC_INT32   = 6'd2;

  localparam logic [ByteW-1:0] FILE_TAG [0:4] = '{8'h52, 8'h45, 8'h44, 8'h49, 8'h53};

  typedef enum logic [2:0] {
    P_MAGIC, P_VERSION, P_OPCODE, P_LEN_FIRST, P_LEN_MORE, P_STRING, P_EXPIRY, P_HALT
  } parse_phase_e;

  typedef enum logic [2:0] {
    F_DBNUM, F_HSIZE, F_ESIZE, F_AUXKEY, F_AUXVAL, F_KEY, F_VALUE
  } field_e;

  typedef enum int unsigned {
    END_OPCODE_FF, END_MARKER, END_TRUNCATED, END_BAD_OPCODE, END_ENCODED_KV,
    END_ENCODED_AUX, END_BAD_MAGIC
  } file_end_e;

  typedef enum int unsigned {
    DRAIN_FREE, DRAIN_COIN, DRAIN_PERIODIC, DRAIN_SLOW
  } drain_mode_e;

  typedef struct packed {
    logic [EventW-1:0] code;
    logic [ByteW-1:0]  data;
    logic [ExpW-1:0]   expiry;
  } parse_event_t;

  typedef struct packed {
    logic             func;
    logic [ByteW-1:0] data;
  } file_item_t;

  class event_scoreboard;
    parse_phase_e      phase;
    field_e            role;
    logic [3:0]        cnt;
    logic [63:0]       acc;
    logic [31:0]       bytes_to_go;
    logic [ExpW-1:0]   held_expiry;
    logic              in_seconds;
    parse_event_t      ev;
    parse_event_t      expected_events[$];
    int unsigned       mismatch_count;
    int unsigned       checked;
    int unsigned       record_count;
    int unsigned       key_bytes;
    int unsigned       value_bytes;
    logic [EventW-1:0] stop_code;

    function new();
      phase          = P_MAGIC;
      role           = F_DBNUM;
      cnt            = '0;
      acc            = '0;
      bytes_to_go    = '0;
      held_expiry    = '0;
      in_seconds     = 1'b0;
      mismatch_count = 0;
      checked        = 0;
      record_count   = 0;
      key_bytes      = 0;
      value_bytes    = 0;
      stop_code      = EV_NONE;
    endfunction

    function void finish_record(logic [ByteW-1:0] b);
      ev          = '{code: EV_REC_DONE, data: b, expiry: held_expiry};
      held_expiry = '0;
      phase       = P_OPCODE;
    endfunction

    function void end_string();
      if (role == F_AUXKEY) begin
        role  = F_AUXVAL;
        phase = P_LEN_FIRST;
      end else if (role == F_KEY) begin
        role  = F_VALUE;
        phase = P_LEN_FIRST;
      end else begin
        phase = P_OPCODE;
      end
    endfunction

    function void end_length(logic [31:0] len, logic special);
      logic [31:0] n;
      n = len;
      case (role)
        F_HSIZE: begin
          role  = F_ESIZE;
          phase = P_LEN_FIRST;
        end
        F_AUXKEY, F_AUXVAL: begin
          if (special) begin
            if (len == 32'(ENC_INT8)) n = 1;
            else if (len == 32'(ENC_INT16)) n = 2;
            else if (len == 32'(ENC_INT32)) n = 4;
            else begin
              ev    = '{code: EV_ENC_STR, data: '0, expiry: '0};
              phase = P_HALT;
              return;
            end
          end
          if (n == 0) end_string();
          else begin
            bytes_to_go = n;
            phase       = P_STRING;
          end
        end
        F_KEY, F_VALUE: begin
          if (special) begin
            ev    = '{code: EV_ENC_STR, data: '0, expiry: '0};
            phase = P_HALT;
          end else if (len == 0) begin
            if (role == F_VALUE) finish_record('0);
            else end_string();
          end else begin
            bytes_to_go = len;
            phase       = P_STRING;
          end
        end
        default: phase = P_OPCODE;
      endcase
    endfunction

    function void note_transfer(logic func, logic [ByteW-1:0] b);
      logic [31:0] len6;
      len6 = {26'd0, b[5:0]};
      ev   = '0;
      if (phase == P_HALT) begin
      end else if (func) begin
        ev.code = (phase == P_OPCODE) ? EV_LOADED_OK : EV_TRUNC;
        phase   = P_HALT;
      end else begin
        case (phase)
          P_MAGIC: begin
            if (b != FILE_TAG[cnt]) acc[0] = 1'b1;
            cnt++;
            if (cnt == MAGIC_LEN) begin
              if (acc[0]) begin
                ev.code = EV_BAD_MAGIC;
                phase   = P_HALT;
              end else begin
                phase = P_VERSION;
              end
              cnt = '0;
              acc = '0;
            end
          end
          P_VERSION: begin
            cnt++;
            if (cnt == VERSION_LEN) begin
              cnt   = '0;
              phase = P_OPCODE;
            end
          end
          P_OPCODE: begin
            case (b)
              OP_SELECT_DB: begin role = F_DBNUM;  phase = P_LEN_FIRST; end
              OP_RESIZE_DB: begin role = F_HSIZE;  phase = P_LEN_FIRST; end
              OP_AUX:       begin role = F_AUXKEY; phase = P_LEN_FIRST; end
              OP_KV_STRING: begin role = F_KEY;    phase = P_LEN_FIRST; end
              OP_EXPIRE_S, OP_EXPIRE_MS: begin
                in_seconds = (b == OP_EXPIRE_S);
                acc        = '0;
                cnt        = '0;
                phase      = P_EXPIRY;
              end
              OP_EOF: begin
                ev.code = EV_LOADED_OK;
                phase   = P_HALT;
              end
              default: begin
                ev.code = EV_BAD_OP;
                phase   = P_HALT;
              end
            endcase
          end
          P_LEN_FIRST: begin
            case (b[7:6])
              LEN_6BIT: end_length(len6, 1'b0);
              LEN_14BIT: begin
                acc   = {58'd0, b[5:0]};
                cnt   = 4'd1;
                phase = P_LEN_MORE;
              end
              LEN_32BIT: begin
                acc   = '0;
                cnt   = 4'd4;
                phase = P_LEN_MORE;
              end
              default: end_length(len6, 1'b1);
            endcase
          end
          P_LEN_MORE: begin
            acc = {32'd0, acc[23:0], b};
            if (cnt != 0) cnt--;
            if (cnt == 0) end_length(acc[31:0], 1'b0);
          end
          P_STRING: begin
            if (bytes_to_go != 0) bytes_to_go--;
            if (role == F_KEY) begin
              ev = '{code: EV_KEY_BYTE, data: b, expiry: '0};
              if (bytes_to_go == 0) end_string();
            end else if (role == F_VALUE) begin
              if (bytes_to_go == 0) finish_record(b);
              else ev = '{code: EV_VAL_BYTE, data: b, expiry: '0};
            end else if (bytes_to_go == 0) begin
              end_string();
            end
          end
          P_EXPIRY: begin
            acc = acc | (64'(b) << (8 * cnt));
            cnt++;
            if (cnt == (in_seconds ? 4'd4 : 4'd8)) begin
              held_expiry = in_seconds ? {32'd0, acc[31:0]} * 64'(MS_PER_S) : acc;
              acc         = '0;
              cnt         = '0;
              phase       = P_OPCODE;
            end
          end
          default: phase = P_HALT;
        endcase
      end
      expected_events.push_back(ev);
    endfunction

    function void check_event(logic [EventW-1:0] code, logic [ByteW-1:0] data,
                              logic [ExpW-1:0] expiry);
      parse_event_t want;
      if (expected_events.size() == 0) begin
        $display("%0t: event %0d (byte %02h, expiry %0h) with no transfer outstanding",
                 $time, code, data, expiry);
        mismatch_count++;
        return;
      end
      want = expected_events.pop_front();
      if (code !== want.code) begin
        $display("%0t: event code mismatch, expected %0d, got %0d", $time, want.code, code);
        mismatch_count++;
      end
      if (data !== want.data) begin
        $display("%0t: out_byte mismatch, expected %02h, got %02h", $time, want.data, data);
        mismatch_count++;
      end
      if (expiry !== want.expiry) begin
        $display("%0t: expire_ms mismatch, expected %0h, got %0h", $time, want.expiry, expiry);
        mismatch_count++;
      end
      checked++;
      case (code)
        EV_KEY_BYTE: key_bytes++;
        EV_VAL_BYTE: value_bytes++;
        EV_REC_DONE: record_count++;
        default:     if (code >= EV_LOADED_OK) stop_code = code;
      endcase
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic             func_i;
  logic [ByteW-1:0] data_byte_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [EventW-1:0] event_res_o;
  logic [ByteW-1:0]  out_byte_o;
  logic [ExpW-1:0]   expire_ms_o;

  event_scoreboard sb = new();
  file_item_t      snapshot_file[$];
  file_end_e       file_end;
  int unsigned     idle_cycles = 0;

  snapshot_stream_parser i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void put(logic [ByteW-1:0] b);
    snapshot_file.push_back('{func: 1'b0, data: b});
  endfunction

  function automatic void put_marker();
    snapshot_file.push_back('{func: 1'b1, data: 8'($urandom_range(0, 255))});
  endfunction

  function automatic void put_text(int unsigned n);
    int unsigned k;
    for (k = 0; k < n; k++) put(8'($urandom_range(0, 255)));
  endfunction

  function automatic int unsigned pick_len();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 80) : $urandom_range(0, 6);
  endfunction

  function automatic void put_length(int unsigned n);
    logic [31:0] nb;
    logic [1:0]  form;
    nb = n;
    if (n < 64) form = 2'($urandom_range(0, 2));
    else if (n < 16384) form = 2'($urandom_range(1, 2));
    else form = LEN_32BIT;
    case (form)
      LEN_6BIT:  put({LEN_6BIT, nb[5:0]});
      LEN_14BIT: begin
        put({LEN_14BIT, nb[13:8]});
        put(nb[7:0]);
      end
      default: begin
        put({LEN_32BIT, 6'($urandom_range(0, 63))});
        put(nb[31:24]);
        put(nb[23:16]);
        put(nb[15:8]);
        put(nb[7:0]);
      end
    endcase
  endfunction

  function automatic void put_size();
    if ($urandom_range(0, 2) == 0) put({LEN_SPECIAL, 6'($urandom_range(0, 63))});
    else put_length($urandom_range(0, 1) ? $urandom : $urandom_range(0, 200));
  endfunction

  function automatic void put_aux_string();
    logic [5:0]  enc;
    int unsigned n;
    if ($urandom_range(0, 2) == 0) begin
      enc = 6'($urandom_range(0, 2));
      put({LEN_SPECIAL, enc});
      case (enc)
        ENC_INT8:  put_text(1);
        ENC_INT16: put_text(2);
        default:   put_text(4);
      endcase
    end else begin
      n = pick_len();
      put_length(n);
      put_text(n);
    end
  endfunction

  function automatic void put_expiry(int unsigned nbytes);
    logic [63:0] v;
    int unsigned k;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = '1;
      default: ;
    endcase
    for (k = 0; k < nbytes; k++) put(v[8*k +: 8]);
  endfunction

  function automatic void put_unit();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      put(OP_KV_STRING);
      n = pick_len();
      put_length(n);
      put_text(n);
      n = pick_len();
      put_length(n);
      put_text(n);
    end else if (pick < 55) begin
      put(OP_EXPIRE_S);
      put_expiry(4);
    end else if (pick < 65) begin
      put(OP_EXPIRE_MS);
      put_expiry(8);
    end else if (pick < 75) begin
      put(OP_SELECT_DB);
      put_size();
    end else if (pick < 85) begin
      put(OP_RESIZE_DB);
      put_size();
      put_size();
    end else begin
      put(OP_AUX);
      put_aux_string();
      put_aux_string();
    end
  endfunction

  function automatic void build_file();
    int unsigned k;
    int unsigned stop_at;
    int unsigned cut;
    int unsigned pick;
    pick     = $urandom_range(0, 12);
    file_end = (pick == 12) ? END_BAD_MAGIC : file_end_e'(pick % 6);
    for (k = 0; k < 5; k++) put(FILE_TAG[k]);
    if (file_end == END_BAD_MAGIC) begin
      k = $urandom_range(0, 4);
      snapshot_file[k].data = snapshot_file[k].data ^ 8'($urandom_range(1, 255));
    end
    put_text(4);
    // special database number, zero and special sizes, encoded aux key, empty aux value,
    // largest seconds expiry, then an empty key and an empty value
    put(OP_SELECT_DB);
    put({LEN_SPECIAL, 6'd5});
    put(OP_RESIZE_DB);
    put({LEN_6BIT, 6'd0});
    put({LEN_SPECIAL, 6'd1});
    put(OP_AUX);
    put({LEN_SPECIAL, ENC_INT8});
    put(8'hAB);
    put({LEN_6BIT, 6'd0});
    put(OP_EXPIRE_S);
    put_text(0);
    repeat (4) put(8'hFF);
    put(OP_KV_STRING);
    put({LEN_6BIT, 6'd0});
    put({LEN_6BIT, 6'd0});
    while (snapshot_file.size() < ITEM_TARGET) put_unit();
    case (file_end)
      END_OPCODE_FF: begin
        put(OP_EOF);
        put_text(8);
      end
      END_MARKER: put_marker();
      END_TRUNCATED: begin
        stop_at = snapshot_file.size();
        put_unit();
        cut = $urandom_range(1, snapshot_file.size() - stop_at - 1);
        while (snapshot_file.size() > stop_at + cut) void'(snapshot_file.pop_back());
        put_marker();
      end
      END_BAD_OPCODE: put(8'($urandom_range(1, OP_AUX - 1)));
      END_ENCODED_KV: begin
        put(OP_KV_STRING);
        if ($urandom_range(0, 1)) begin
          k = pick_len();
          put_length(k);
          put_text(k);
        end
        put({LEN_SPECIAL, 6'($urandom_range(0, 63))});
      end
      END_ENCODED_AUX: begin
        put(OP_AUX);
        if ($urandom_range(0, 1)) put_aux_string();
        put({LEN_SPECIAL, 6'($urandom_range(3, 63))});
      end
      default: put(OP_EOF);
    endcase
    repeat ($urandom_range(6, 16)) begin
      if ($urandom_range(0, 2) == 0) put_marker();
      else put(8'($urandom_range(0, 255)));
    end
    put_marker();
  endfunction

  task automatic send_item(input file_item_t item);
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    func_i      <= item.func;
    data_byte_i <= item.data;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic play_file();
    int unsigned idx;
    int unsigned burst;
    int unsigned gap;
    int unsigned k;
    idx = 0;
    while (idx < snapshot_file.size()) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      for (k = 0; k < burst && idx < snapshot_file.size(); k++) begin
        send_item(snapshot_file[idx]);
        idx++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        @(negedge clk_i);
        in_valid_i  <= 1'b0;
        func_i      <= 1'($urandom_range(0, 1));
        data_byte_i <= 8'($urandom_range(0, 255));
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_transfer(func_i, data_byte_i);
      if (out_valid_o && out_ready_i) sb.check_event(event_res_o, out_byte_o, expire_ms_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : drain_side
    int unsigned cyc;
    int unsigned hold_at;
    int unsigned span;
    drain_mode_e mode;
    bit          held;
    out_ready_i = 1'b0;
    cyc         = 0;
    held        = 1'b0;
    hold_at     = $urandom_range(150, 350);
    forever begin
      mode = drain_mode_e'($urandom_range(0, 3));
      span = $urandom_range(8, 60);
      repeat (span) begin
        @(negedge clk_i);
        cyc++;
        if (!held && cyc >= hold_at) begin
          // hold off so the result register fills and the input stalls
          out_ready_i <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk_i);
          cyc  += HOLD_CYCLES;
          held  = 1'b1;
        end
        case (mode)
          DRAIN_FREE:     out_ready_i <= 1'b1;
          DRAIN_COIN:     out_ready_i <= 1'($urandom_range(0, 1));
          DRAIN_PERIODIC: out_ready_i <= (cyc % 3 != 0);
          default:        out_ready_i <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    func_i      = 1'b0;
    data_byte_i = '0;
    build_file();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    play_file();
    while (sb.expected_events.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("%0d transfers checked: %0d records, %0d key bytes, %0d value bytes",
             sb.checked, sb.record_count, sb.key_bytes, sb.value_bytes);
    $display("file ended by %s, stop event %0d, output held off %0d cycles mid-stream",
             file_end.name(), sb.stop_code, HOLD_CYCLES);
    if (sb.mismatch_count == 0 && sb.expected_events.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/ssp_pkg.sv
design/snapshot_stream_parser.sv
tb/snapshot_stream_parser_test.sv
